// ===== hw/rtl/fault_debounce_aggregator_core_defines.svh =====
// ----------------------------------------------------------------------------
// Fault debounce aggregator: assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i; only FDAGG_ASSERT is disabled by rst_ni.
// ----------------------------------------------------------------------------
`ifndef FAULT_DEBOUNCE_AGGREGATOR_CORE_DEFINES_SVH
`define FAULT_DEBOUNCE_AGGREGATOR_CORE_DEFINES_SVH

// Checked only while out of reset.
`define FDAGG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define FDAGG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/fdagg_pkg.sv =====
// ----------------------------------------------------------------------------
// fdagg_pkg
// Types and constants of the fault debounce aggregator.
// ----------------------------------------------------------------------------
`default_nettype none

package fdagg_pkg;

  localparam int unsigned NUM_CH = 4;

  localparam logic [15:0] TICK_MS  = 16'd4;
  localparam logic [15:0] HOLD_MAX = 16'd65500;
  localparam logic [12:0] SUM_MAX  = 13'd8000;

  // Channel order, also the bit order of channel_latches.
  localparam int unsigned CH_AUX       = 0;
  localparam int unsigned CH_ENGINE    = 1;
  localparam int unsigned CH_CONVERTER = 2;
  localparam int unsigned CH_SUM       = 3;

  typedef enum logic [3:0] {
    REG_AUX_ON        = 4'd0,
    REG_AUX_OFF       = 4'd1,
    REG_ENGINE_ON     = 4'd2,
    REG_ENGINE_OFF    = 4'd3,
    REG_CONVERTER_ON  = 4'd4,
    REG_CONVERTER_OFF = 4'd5,
    REG_SUM_ON        = 4'd6,
    REG_SUM_OFF       = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] on_delay;
    logic [15:0] off_delay;
  } delay_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fault_debounce_aggregator_core.sv =====
// ----------------------------------------------------------------------------
// fault_debounce_aggregator_core
// Four-channel asymmetric-delay fault debounce with global fault output.
// ----------------------------------------------------------------------------
// Each input transfer is one 4 ms task tick. Four conditions are qualified
// (any aux flag, engine loss, converter loss, estimate below raw sum); each
// has an on and off delay in ms loaded on a condition edge (capped at 65500)
// and then counted down by 4 per tick. An expired counter sets or clears the
// channel latch. Every tick yields exactly one result: raw sum clamped to
// 0..8000, the four latches, and the global fault. Throughput is one tick
// per clock while the result register is drained; a tick passes the input
// register, then the channel update feeding the result register.
// Delay registers may be written only while no tick is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fault_debounce_aggregator_core_defines.svh"

module fault_debounce_aggregator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // tick input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [4:0] aux_fault_flags, [5] engine_loss_fault, [6] converter_loss_fault,
  // [19:7] sum_estimate, [35:20] sum_raw, [36] adaptive_fault, [39:37] zero
  input  logic [39:0] s_axis_tdata_i,
  // result output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [12:0] sum_checked, [16:13] channel_latches, [17] global_fault,
  // [23:18] zero
  output logic [23:0] m_axis_tdata_o
);

  localparam int unsigned NCh = fdagg_pkg::NUM_CH;

  // Delay registers, one pair per channel.
  fdagg_pkg::delay_cfg_t delay_cfg_q [NCh];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCh; i++) begin
        delay_cfg_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fdagg_pkg::REG_AUX_ON:        delay_cfg_q[fdagg_pkg::CH_AUX].on_delay        <= cfg_wdata_i;
        fdagg_pkg::REG_AUX_OFF:       delay_cfg_q[fdagg_pkg::CH_AUX].off_delay       <= cfg_wdata_i;
        fdagg_pkg::REG_ENGINE_ON:     delay_cfg_q[fdagg_pkg::CH_ENGINE].on_delay     <= cfg_wdata_i;
        fdagg_pkg::REG_ENGINE_OFF:    delay_cfg_q[fdagg_pkg::CH_ENGINE].off_delay    <= cfg_wdata_i;
        fdagg_pkg::REG_CONVERTER_ON:  delay_cfg_q[fdagg_pkg::CH_CONVERTER].on_delay  <= cfg_wdata_i;
        fdagg_pkg::REG_CONVERTER_OFF: delay_cfg_q[fdagg_pkg::CH_CONVERTER].off_delay <= cfg_wdata_i;
        fdagg_pkg::REG_SUM_ON:        delay_cfg_q[fdagg_pkg::CH_SUM].on_delay        <= cfg_wdata_i;
        fdagg_pkg::REG_SUM_OFF:       delay_cfg_q[fdagg_pkg::CH_SUM].off_delay       <= cfg_wdata_i;
        default: ;  // indexes past the last register are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register. It advances into the result register whenever that one
  // is empty or being drained, so a transfer can land every cycle.
  // --------------------------------------------------------------------------
  logic        in_valid_q;
  logic [36:0] in_data_q;
  logic        out_valid_q;
  logic [17:0] out_data_q;
  logic        advance;
  logic        in_xfer;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_data_q <= s_axis_tdata_i[36:0];
    end
  end

  // Field unpack
  logic [4:0]         aux_flags;
  logic               engine_loss;
  logic               converter_loss;
  logic [12:0]        sum_estimate;
  logic signed [15:0] sum_raw;
  logic               adaptive_fault;

  assign aux_flags      = in_data_q[4:0];
  assign engine_loss    = in_data_q[5];
  assign converter_loss = in_data_q[6];
  assign sum_estimate   = in_data_q[19:7];
  assign sum_raw        = in_data_q[35:20];
  assign adaptive_fault = in_data_q[36];

  // Estimate is unsigned, raw is signed: compare both at 17 bits signed.
  logic signed [16:0] est_ext;
  logic signed [16:0] raw_ext;
  logic [NCh-1:0]     cond;
  logic [NCh-1:0]     latch_next;
  logic [12:0]        sum_checked;

  assign est_ext = signed'({4'b0000, sum_estimate});
  assign raw_ext = signed'({sum_raw[15], sum_raw});

  assign cond[fdagg_pkg::CH_AUX]       = |aux_flags;
  assign cond[fdagg_pkg::CH_ENGINE]    = engine_loss;
  assign cond[fdagg_pkg::CH_CONVERTER] = converter_loss;
  assign cond[fdagg_pkg::CH_SUM]       = est_ext < raw_ext;

  always_comb begin
    if (sum_raw[15]) begin
      sum_checked = '0;
    end else if (sum_raw > signed'({3'b000, fdagg_pkg::SUM_MAX})) begin
      sum_checked = fdagg_pkg::SUM_MAX;
    end else begin
      sum_checked = sum_raw[12:0];
    end
  end

  // Channel state moves only when a tick passes into the result register.
  for (genvar g = 0; g < NCh; g++) begin : g_ch
    fdagg_channel u_ch (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (advance),
      .cond_i  (cond[g]),
      .cfg_i   (delay_cfg_q[g]),
      .latch_o (latch_next[g])
    );
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {(|latch_next) || adaptive_fault, latch_next, sum_checked};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b000000, out_data_q};

  `FDAGG_ASSERT(a_advance_fills, advance |=> m_axis_tvalid_o, "tick lost on way to result register")
  `FDAGG_ASSERT(a_sum_range, m_axis_tvalid_o |-> m_axis_tdata_o[12:0] <= fdagg_pkg::SUM_MAX, "sum_checked out of range")
  `FDAGG_ASSERT(a_global_covers, m_axis_tvalid_o && (m_axis_tdata_o[16:13] != 4'b0000) |-> m_axis_tdata_o[17], "latch set without global fault")

endmodule

`default_nettype wire

// ===== hw/rtl/fdagg_channel.sv =====
// ----------------------------------------------------------------------------
// fdagg_channel
// One debounce channel: edge-loaded hold counter and set/reset latch.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fault_debounce_aggregator_core_defines.svh"

module fdagg_channel (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,   // one tick is applied
  input  logic               cond_i,
  input  fdagg_pkg::delay_cfg_t cfg_i,
  output logic               latch_o   // latch value after this tick
);

  logic [15:0] cnt_q, cnt_d;
  logic [15:0] delay_sel;
  logic        prev_q;
  logic        latch_q, latch_d;

  always_comb begin
    delay_sel = cond_i ? cfg_i.on_delay : cfg_i.off_delay;
    if (cond_i != prev_q) begin
      cnt_d = (delay_sel > fdagg_pkg::HOLD_MAX) ? fdagg_pkg::HOLD_MAX : delay_sel;
    end else if (cnt_q > fdagg_pkg::TICK_MS) begin
      cnt_d = cnt_q - fdagg_pkg::TICK_MS;
    end else begin
      cnt_d = '0;
    end
    // Counter expired: condition drives the latch.
    latch_d = (cnt_d == '0) ? cond_i : latch_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      prev_q  <= 1'b0;
      latch_q <= 1'b0;
    end else if (step_i) begin
      cnt_q   <= cnt_d;
      prev_q  <= cond_i;
      latch_q <= latch_d;
    end
  end

  assign latch_o = latch_d;

  `FDAGG_ASSERT_ALWAYS(a_cnt_bounded, cnt_q <= fdagg_pkg::HOLD_MAX, "hold counter above limit")
  `FDAGG_ASSERT(a_expired_follows, step_i && (cond_i == prev_q) && (cnt_q == '0) |=> latch_q == prev_q, "expired counter did not make latch follow condition")

endmodule

`default_nettype wire
